>>> design/apem_pkg.sv
// ----------------------------------------------------------------------------
// apem_pkg
// Widths, register codes and internal bundles of the point error metric.
// ----------------------------------------------------------------------------
package apem_pkg;

  // item fields
  localparam int COORD_W  = 24;
  localparam int NRM_W    = 16;
  localparam int ERR_W    = 25;
  localparam int RATIO_W  = 32;
  localparam int RADIUS_W = 24;
  localparam int FACTOR_W = 16;

  // internal datapath widths
  localparam int DIFF_W = COORD_W + 1;   // point difference
  localparam int ESQ_W  = 50;            // squared Euclidean distance
  localparam int MAG_W  = 41;            // |d.n|, |d x n| components
  localparam int SQ2_W  = 84;            // squares of the above
  localparam int NN_W   = 32;            // |n|^2
  localparam int AF_W   = MAG_W + FACTOR_W;
  localparam int EDEN_W = 64;            // |n|^2 * f^2
  localparam int ENUM_W = 116;           // (|d.n| f)^2 + |d x n|^2 * 2^16

  // configuration port
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 24'd256;
  localparam logic [FACTOR_W-1:0] FACTOR_RST = 16'd512;

  typedef enum logic {
    REG_RADIUS = 1'b0,
    REG_FACTOR = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] eval_x;
    logic signed [COORD_W-1:0] eval_y;
    logic signed [COORD_W-1:0] eval_z;
    logic signed [COORD_W-1:0] ref_x;
    logic signed [COORD_W-1:0] ref_y;
    logic signed [COORD_W-1:0] ref_z;
    logic signed [NRM_W-1:0]   surf_nx;
    logic signed [NRM_W-1:0]   surf_ny;
    logic signed [NRM_W-1:0]   surf_nz;
    logic                      surf_valid;
  } sample_t;

  // operands of the four root units
  typedef struct packed {
    logic [ESQ_W-1:0]  esq;
    logic [SQ2_W-1:0]  dot2;
    logic [SQ2_W-1:0]  c2;
    logic [NN_W-1:0]   nn;
    logic [ENUM_W-1:0] ell_num;
    logic [EDEN_W-1:0] ell_den;
    logic              used;
  } root_in_t;

  // results that ride along the divider
  typedef struct packed {
    logic [ERR_W-1:0] euclid;
    logic [ERR_W-1:0] along;
    logic [ERR_W-1:0] across;
    logic             used;
  } side_t;

endpackage

>>> design/apem_sample_if.sv
// ----------------------------------------------------------------------------
// apem_sample_if
// Input channel: point pair and surface normal, valid/ready.
// ----------------------------------------------------------------------------
interface apem_sample_if;
  logic                                valid;
  logic                                ready;
  logic signed [apem_pkg::COORD_W-1:0] eval_x;
  logic signed [apem_pkg::COORD_W-1:0] eval_y;
  logic signed [apem_pkg::COORD_W-1:0] eval_z;
  logic signed [apem_pkg::COORD_W-1:0] ref_x;
  logic signed [apem_pkg::COORD_W-1:0] ref_y;
  logic signed [apem_pkg::COORD_W-1:0] ref_z;
  logic signed [apem_pkg::NRM_W-1:0]   surf_nx;
  logic signed [apem_pkg::NRM_W-1:0]   surf_ny;
  logic signed [apem_pkg::NRM_W-1:0]   surf_nz;
  logic                                surf_valid;

  modport source (output valid, eval_x, eval_y, eval_z, ref_x, ref_y, ref_z,
                  surf_nx, surf_ny, surf_nz, surf_valid, input ready);
  modport sink (input valid, eval_x, eval_y, eval_z, ref_x, ref_y, ref_z,
                surf_nx, surf_ny, surf_nz, surf_valid, output ready);
endinterface

>>> design/apem_result_if.sv
// ----------------------------------------------------------------------------
// apem_result_if
// Output channel: error metrics of one point pair, valid/ready.
// ----------------------------------------------------------------------------
interface apem_result_if;
  logic                          valid;
  logic                          ready;
  logic [apem_pkg::ERR_W-1:0]    euclid_err;
  logic [apem_pkg::ERR_W-1:0]    along_err;
  logic [apem_pkg::ERR_W-1:0]    across_err;
  logic [apem_pkg::ERR_W-1:0]    ellipse_err;
  logic [apem_pkg::RATIO_W-1:0]  err_ratio;
  logic                          normal_used;
  logic                          exceeded;

  modport source (output valid, euclid_err, along_err, across_err, ellipse_err,
                  err_ratio, normal_used, exceeded, input ready);
  modport sink (input valid, euclid_err, along_err, across_err, ellipse_err,
                err_ratio, normal_used, exceeded, output ready);
endinterface

>>> design/apem_front.sv
// ----------------------------------------------------------------------------
// apem_front
// Seven-stage front end: differences, products, dot/cross sums, squares.
// ----------------------------------------------------------------------------
module apem_front (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                en,
  input  logic                                in_valid,
  input  apem_pkg::sample_t                   smp,
  input  logic [apem_pkg::FACTOR_W-1:0]       factor,
  output logic                                out_valid,
  output apem_pkg::root_in_t                  ri
);

  localparam int DIFF_W = apem_pkg::DIFF_W;
  localparam int NRM_W  = apem_pkg::NRM_W;
  localparam int PRD_W  = DIFF_W + NRM_W;
  localparam int SQ_W   = 2 * DIFF_W;
  localparam int NSQ_W  = 2 * NRM_W;
  localparam int DOT_W  = PRD_W + 2;
  localparam int CRS_W  = PRD_W + 1;
  localparam int MAG_W  = apem_pkg::MAG_W;
  localparam int LO_W   = 21;
  localparam int HI_W   = MAG_W - LO_W;
  localparam int AF_W   = apem_pkg::AF_W;
  localparam int AF_LO  = 29;
  localparam int AF_HI  = AF_W - AF_LO;
  localparam int F_W    = apem_pkg::FACTOR_W;
  localparam int F2_W   = 2 * F_W;
  localparam int SQ2_W  = apem_pkg::SQ2_W;
  localparam int ENUM_W = apem_pkg::ENUM_W;
  localparam int EDEN_W = apem_pkg::EDEN_W;
  localparam int ESQ_W  = apem_pkg::ESQ_W;
  localparam int NN_W   = apem_pkg::NN_W;
  localparam int LANES  = 4;   // |d.n|, |cx|, |cy|, |cz|

  // stage A: differences
  logic                     a_vld, a_used;
  logic signed [DIFF_W-1:0] a_dx, a_dy, a_dz;
  logic signed [NRM_W-1:0]  a_nx, a_ny, a_nz;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else if (en) a_vld <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_dx   <= DIFF_W'(smp.eval_x) - DIFF_W'(smp.ref_x);
      a_dy   <= DIFF_W'(smp.eval_y) - DIFF_W'(smp.ref_y);
      a_dz   <= DIFF_W'(smp.eval_z) - DIFF_W'(smp.ref_z);
      a_nx   <= smp.surf_nx;
      a_ny   <= smp.surf_ny;
      a_nz   <= smp.surf_nz;
      a_used <= smp.surf_valid &&
                ((|smp.surf_nx) || (|smp.surf_ny) || (|smp.surf_nz));
    end
  end

  // stage B: all single products
  logic                    b_vld, b_used;
  logic signed [SQ_W-1:0]  b_sxx, b_syy, b_szz;
  logic signed [PRD_W-1:0] b_pxx, b_pyy, b_pzz;
  logic signed [PRD_W-1:0] b_pyz, b_pzy, b_pzx, b_pxz, b_pxy, b_pyx;
  logic signed [NSQ_W-1:0] b_nxx, b_nyy, b_nzz;
  logic [F_W-1:0]          b_fe;
  logic [F2_W-1:0]         b_f2;
  logic [F_W-1:0]          fe;

  // a zero factor acts as the smallest nonzero one
  assign fe = (factor == '0) ? F_W'(1) : factor;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else if (en) b_vld <= a_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b_sxx  <= SQ_W'(a_dx) * SQ_W'(a_dx);
      b_syy  <= SQ_W'(a_dy) * SQ_W'(a_dy);
      b_szz  <= SQ_W'(a_dz) * SQ_W'(a_dz);
      b_pxx  <= PRD_W'(a_dx) * PRD_W'(a_nx);
      b_pyy  <= PRD_W'(a_dy) * PRD_W'(a_ny);
      b_pzz  <= PRD_W'(a_dz) * PRD_W'(a_nz);
      b_pyz  <= PRD_W'(a_dy) * PRD_W'(a_nz);
      b_pzy  <= PRD_W'(a_dz) * PRD_W'(a_ny);
      b_pzx  <= PRD_W'(a_dz) * PRD_W'(a_nx);
      b_pxz  <= PRD_W'(a_dx) * PRD_W'(a_nz);
      b_pxy  <= PRD_W'(a_dx) * PRD_W'(a_ny);
      b_pyx  <= PRD_W'(a_dy) * PRD_W'(a_nx);
      b_nxx  <= NSQ_W'(a_nx) * NSQ_W'(a_nx);
      b_nyy  <= NSQ_W'(a_ny) * NSQ_W'(a_ny);
      b_nzz  <= NSQ_W'(a_nz) * NSQ_W'(a_nz);
      b_fe   <= fe;
      b_f2   <= F2_W'(fe) * F2_W'(fe);
      b_used <= a_used;
    end
  end

  // stage C: sums and magnitudes
  logic                    c_vld, c_used;
  logic [ESQ_W-1:0]        c_esq;
  logic [NN_W-1:0]         c_nn;
  logic [MAG_W-1:0]        c_mag [0:LANES-1];
  logic [F_W-1:0]          c_fe;
  logic [F2_W-1:0]         c_f2;
  logic signed [DOT_W-1:0] dot_s, dot_a;
  logic signed [CRS_W-1:0] cx_s, cy_s, cz_s, cx_a, cy_a, cz_a;

  always_comb begin
    dot_s = DOT_W'(b_pxx) + DOT_W'(b_pyy) + DOT_W'(b_pzz);
    cx_s  = CRS_W'(b_pyz) - CRS_W'(b_pzy);
    cy_s  = CRS_W'(b_pzx) - CRS_W'(b_pxz);
    cz_s  = CRS_W'(b_pxy) - CRS_W'(b_pyx);
    dot_a = dot_s[DOT_W-1] ? -dot_s : dot_s;
    cx_a  = cx_s[CRS_W-1] ? -cx_s : cx_s;
    cy_a  = cy_s[CRS_W-1] ? -cy_s : cy_s;
    cz_a  = cz_s[CRS_W-1] ? -cz_s : cz_s;
  end

  always_ff @(posedge clk) begin
    if (rst) c_vld <= 1'b0;
    else if (en) c_vld <= b_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_esq    <= ESQ_W'(b_sxx) + ESQ_W'(b_syy) + ESQ_W'(b_szz);
      c_nn     <= NN_W'(b_nxx) + NN_W'(b_nyy) + NN_W'(b_nzz);
      c_mag[0] <= dot_a[MAG_W-1:0];
      c_mag[1] <= cx_a[MAG_W-1:0];
      c_mag[2] <= cy_a[MAG_W-1:0];
      c_mag[3] <= cz_a[MAG_W-1:0];
      c_fe     <= b_fe;
      c_f2     <= b_f2;
      c_used   <= b_used;
    end
  end

  // stage D: half-word partial products
  logic                     d_vld, d_used;
  logic [2*HI_W-1:0]        d_hh [0:LANES-1];
  logic [HI_W+LO_W-1:0]     d_hl [0:LANES-1];
  logic [2*LO_W-1:0]        d_ll [0:LANES-1];
  logic [AF_W-1:0]          d_af;
  logic [EDEN_W-1:0]        d_eden;
  logic [ESQ_W-1:0]         d_esq;
  logic [NN_W-1:0]          d_nn;

  always_ff @(posedge clk) begin
    if (rst) d_vld <= 1'b0;
    else if (en) d_vld <= c_vld;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_pp
    always_ff @(posedge clk) begin
      if (en) begin
        d_hh[i] <= (2*HI_W)'(c_mag[i][MAG_W-1:LO_W]) *
                   (2*HI_W)'(c_mag[i][MAG_W-1:LO_W]);
        d_hl[i] <= (HI_W+LO_W)'(c_mag[i][MAG_W-1:LO_W]) *
                   (HI_W+LO_W)'(c_mag[i][LO_W-1:0]);
        d_ll[i] <= (2*LO_W)'(c_mag[i][LO_W-1:0]) * (2*LO_W)'(c_mag[i][LO_W-1:0]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_af   <= AF_W'(c_mag[0]) * AF_W'(c_fe);
      d_eden <= EDEN_W'(c_nn) * EDEN_W'(c_f2);
      d_esq  <= c_esq;
      d_nn   <= c_nn;
      d_used <= c_used;
    end
  end

  // stage E: lane squares, partial products of (|d.n| f)^2
  logic                     e_vld, e_used;
  logic [SQ2_W-1:0]         e_sq [0:LANES-1];
  logic [2*AF_HI-1:0]       e_ahh;
  logic [AF_HI+AF_LO-1:0]   e_ahl;
  logic [2*AF_LO-1:0]       e_all;
  logic [EDEN_W-1:0]        e_eden;
  logic [ESQ_W-1:0]         e_esq;
  logic [NN_W-1:0]          e_nn;

  always_ff @(posedge clk) begin
    if (rst) e_vld <= 1'b0;
    else if (en) e_vld <= d_vld;
  end

  for (genvar i = 0; i < LANES; i++) begin : g_sq
    always_ff @(posedge clk) begin
      if (en) begin
        e_sq[i] <= (SQ2_W'(d_hh[i]) << (2*LO_W)) + (SQ2_W'(d_hl[i]) << (LO_W+1)) +
                   SQ2_W'(d_ll[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      e_ahh  <= (2*AF_HI)'(d_af[AF_W-1:AF_LO]) * (2*AF_HI)'(d_af[AF_W-1:AF_LO]);
      e_ahl  <= (AF_HI+AF_LO)'(d_af[AF_W-1:AF_LO]) * (AF_HI+AF_LO)'(d_af[AF_LO-1:0]);
      e_all  <= (2*AF_LO)'(d_af[AF_LO-1:0]) * (2*AF_LO)'(d_af[AF_LO-1:0]);
      e_eden <= d_eden;
      e_esq  <= d_esq;
      e_nn   <= d_nn;
      e_used <= d_used;
    end
  end

  // stage F: |d x n|^2 and (|d.n| f)^2
  logic              f_vld, f_used;
  logic [SQ2_W-1:0]  f_dot2, f_c2;
  logic [ENUM_W-1:0] f_afsq;
  logic [EDEN_W-1:0] f_eden;
  logic [ESQ_W-1:0]  f_esq;
  logic [NN_W-1:0]   f_nn;

  always_ff @(posedge clk) begin
    if (rst) f_vld <= 1'b0;
    else if (en) f_vld <= e_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f_dot2 <= e_sq[0];
      f_c2   <= e_sq[1] + e_sq[2] + e_sq[3];
      f_afsq <= (ENUM_W'(e_ahh) << (2*AF_LO)) + (ENUM_W'(e_ahl) << (AF_LO+1)) +
                ENUM_W'(e_all);
      f_eden <= e_eden;
      f_esq  <= e_esq;
      f_nn   <= e_nn;
      f_used <= e_used;
    end
  end

  // stage G: root operands; without a normal the ellipse root sees the
  // Euclidean square and the along/across roots see zero
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (en) out_valid <= f_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ri.esq     <= f_esq;
      ri.dot2    <= f_used ? f_dot2 : '0;
      ri.c2      <= f_used ? f_c2 : '0;
      ri.nn      <= f_used ? f_nn : NN_W'(1);
      ri.ell_num <= f_used ? f_afsq + (ENUM_W'(f_c2) << 16) : ENUM_W'(f_esq);
      ri.ell_den <= f_used ? f_eden : EDEN_W'(1);
      ri.used    <= f_used;
    end
  end

endmodule

>>> design/apem_root.sv
// ----------------------------------------------------------------------------
// apem_root
// Pipelined root of a quotient: largest e < 2^ERR_W with e*e*den <= num.
// One result bit per stage, remainder and e*den carried along.
// ----------------------------------------------------------------------------
module apem_root #(
  parameter int NUM_W = 50,
  parameter int DEN_W = 1
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [NUM_W-1:0]           num,
  input  logic [DEN_W-1:0]           den,
  output logic                       out_valid,
  output logic [apem_pkg::ERR_W-1:0] root
);

  localparam int ROOT_W = apem_pkg::ERR_W;
  localparam int P_W    = DEN_W + ROOT_W;
  localparam int T_W    = DEN_W + 2 * ROOT_W + 1;
  localparam int C_W    = (T_W > NUM_W) ? T_W : NUM_W;

  logic [NUM_W-1:0]  rem   [0:ROOT_W-1];
  logic [P_W-1:0]    prod  [0:ROOT_W-1];
  logic [DEN_W-1:0]  den_q [0:ROOT_W-1];
  logic [ROOT_W-1:0] est   [0:ROOT_W];
  logic              vld   [0:ROOT_W];

  assign rem[0]   = num;
  assign prod[0]  = '0;
  assign den_q[0] = den;
  assign est[0]   = '0;
  assign vld[0]   = in_valid;

  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    localparam int B = ROOT_W - 1 - k;
    logic [C_W-1:0] trial;
    logic           fit;

    // (e + 2^B)^2 den - e^2 den = e den 2^(B+1) + den 2^(2B)
    always_comb begin
      trial = (C_W'(prod[k]) << (B + 1)) + (C_W'(den_q[k]) << (2 * B));
      fit   = trial <= C_W'(rem[k]);
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) est[k+1] <= est[k] | (ROOT_W'(fit) << B);
    end

    if (k < ROOT_W - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1]   <= fit ? rem[k] - trial[NUM_W-1:0] : rem[k];
          prod[k+1]  <= fit ? prod[k] + (P_W'(den_q[k]) << B) : prod[k];
          den_q[k+1] <= den_q[k];
        end
      end
    end
  end

  assign out_valid = vld[ROOT_W];
  assign root      = est[ROOT_W];

endmodule

>>> design/apem_div.sv
// ----------------------------------------------------------------------------
// apem_div
// Pipelined ratio ellipse_err * 2^16 / radius, one quotient bit per stage,
// with saturation and the radius compare.
// ----------------------------------------------------------------------------
module apem_div #(
  parameter int SIDE_W = 76
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [apem_pkg::ERR_W-1:0]    ell,
  input  logic [apem_pkg::RADIUS_W-1:0] radius,
  input  logic [SIDE_W-1:0]             side,
  output logic                          out_valid,
  output logic [apem_pkg::ERR_W-1:0]    ell_out,
  output logic [apem_pkg::RATIO_W-1:0]  ratio,
  output logic                          exceeded,
  output logic [SIDE_W-1:0]             side_out
);

  localparam int ERR_W   = apem_pkg::ERR_W;
  localparam int Q_W     = apem_pkg::RATIO_W;
  localparam int RAD_W   = apem_pkg::RADIUS_W;
  localparam int FRAC_W  = 16;
  localparam int REM_W   = ERR_W + FRAC_W;
  localparam int DT_W    = Q_W + RAD_W;

  typedef struct packed {
    logic zero;
    logic sat;
    logic exc;
  } div_flags_t;

  logic [REM_W-1:0]  rem   [0:Q_W-1];
  logic [Q_W-1:0]    quo   [0:Q_W];
  div_flags_t        flg   [0:Q_W];
  logic [ERR_W-1:0]  ell_q [0:Q_W];
  logic [SIDE_W-1:0] sd_q  [0:Q_W];
  logic              vld   [0:Q_W];

  assign rem[0]       = {ell, {FRAC_W{1'b0}}};
  assign quo[0]       = '0;
  assign flg[0].zero  = (ell == '0);
  // quotient reaches 2^32 exactly when ell >= radius * 2^16 (also radius 0)
  assign flg[0].sat   = REM_W'(ell) >= {1'b0, radius, {FRAC_W{1'b0}}};
  assign flg[0].exc   = ell > ERR_W'(radius);
  assign ell_q[0]     = ell;
  assign sd_q[0]      = side;
  assign vld[0]       = in_valid;

  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    localparam int I = Q_W - 1 - k;
    logic [DT_W-1:0] trial;
    logic            fit;

    always_comb begin
      trial = DT_W'(radius) << I;
      fit   = DT_W'(rem[k]) >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) vld[k+1] <= 1'b0;
      else if (en) vld[k+1] <= vld[k];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        quo[k+1]   <= quo[k] | (Q_W'(fit) << I);
        flg[k+1]   <= flg[k];
        ell_q[k+1] <= ell_q[k];
        sd_q[k+1]  <= sd_q[k];
      end
    end

    if (k < Q_W - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) rem[k+1] <= fit ? rem[k] - trial[REM_W-1:0] : rem[k];
      end
    end
  end

  always_comb begin
    if (flg[Q_W].zero) ratio = '0;
    else if (flg[Q_W].sat) ratio = '1;
    else ratio = quo[Q_W];
  end

  assign out_valid = vld[Q_W];
  assign ell_out   = ell_q[Q_W];
  assign exceeded  = flg[Q_W].exc;
  assign side_out  = sd_q[Q_W];

endmodule

>>> design/anisotropic_point_error_metric.sv
// ----------------------------------------------------------------------------
// anisotropic_point_error_metric
// Euclidean, along-normal, tangential and ellipsoidal error of a point pair.
// ----------------------------------------------------------------------------
// Usage:
//   sample : one item per point pair (evaluated point, reference point,
//            surface normal, normal valid flag), valid/ready.
//   result : one item per sample, in order, valid/ready.
//   APB    : normal_radius at 0x0, tangent_factor at 0x4; write while idle.
// Pipeline: from acceptance of a sample to its result being valid, a sample
//   passes 7 front stages, 25 root stages, 32 divider stages and the output register.
// Throughput: one item per cycle while results are taken. All stages advance
//   together; the result register frees up whenever it is empty or being taken,
//   so sample.ready follows result.ready while a result is pending.
// Stall: with the result held and not taken, the whole pipe freezes; no item
//   is dropped or duplicated.
// Reset: clears all valid bits; normal_radius = 1.0, tangent_factor = 2.0.
// ----------------------------------------------------------------------------
module anisotropic_point_error_metric (
  input  logic                              clk,
  input  logic                              rst,
  apem_sample_if.sink                       sample,
  apem_result_if.source                     result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [apem_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [apem_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [apem_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int ERR_W  = apem_pkg::ERR_W;
  localparam int DATA_W = apem_pkg::APB_DATA_W;
  localparam int SIDE_W = $bits(apem_pkg::side_t);

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic [apem_pkg::RADIUS_W-1:0] normal_radius;
  logic [apem_pkg::FACTOR_W-1:0] tangent_factor;
  apem_pkg::reg_idx_t            reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = apem_pkg::reg_idx_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_radius  <= apem_pkg::RADIUS_RST;
      tangent_factor <= apem_pkg::FACTOR_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_sel)
        apem_pkg::REG_RADIUS: normal_radius  <= pwdata[apem_pkg::RADIUS_W-1:0];
        apem_pkg::REG_FACTOR: tangent_factor <= pwdata[apem_pkg::FACTOR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      apem_pkg::REG_RADIUS: prdata = DATA_W'(normal_radius);
      apem_pkg::REG_FACTOR: prdata = DATA_W'(tangent_factor);
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // pipeline advance: the whole pipe moves when the result slot is free
  // --------------------------------------------------------------------------
  logic en;
  assign en           = !result.valid || result.ready;
  assign sample.ready = en;

  apem_pkg::sample_t smp;
  always_comb begin
    smp.eval_x     = sample.eval_x;
    smp.eval_y     = sample.eval_y;
    smp.eval_z     = sample.eval_z;
    smp.ref_x      = sample.ref_x;
    smp.ref_y      = sample.ref_y;
    smp.ref_z      = sample.ref_z;
    smp.surf_nx    = sample.surf_nx;
    smp.surf_ny    = sample.surf_ny;
    smp.surf_nz    = sample.surf_nz;
    smp.surf_valid = sample.surf_valid;
  end

  // front end: products and squares of the point difference and the normal
  logic               front_vld;
  apem_pkg::root_in_t ri;

  apem_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (sample.valid),
    .smp       (smp),
    .factor    (tangent_factor),
    .out_valid (front_vld),
    .ri        (ri)
  );

  // --------------------------------------------------------------------------
  // four root units in lockstep
  //   euclid  = sqrt(|d|^2)
  //   along   = sqrt((d.n)^2 / |n|^2)
  //   across  = sqrt(|d x n|^2 / |n|^2)
  //   ellipse = sqrt((((d.n) f)^2 + |d x n|^2 2^16) / (|n|^2 f^2))
  // --------------------------------------------------------------------------
  logic [3:0]       root_vld;
  logic [ERR_W-1:0] euclid, along, across, ellipse;

  apem_root #(.NUM_W(apem_pkg::ESQ_W), .DEN_W(1)) u_euclid (
    .clk (clk), .rst (rst), .en (en), .in_valid (front_vld),
    .num (ri.esq), .den (1'b1), .out_valid (root_vld[0]), .root (euclid)
  );

  apem_root #(.NUM_W(apem_pkg::SQ2_W), .DEN_W(apem_pkg::NN_W)) u_along (
    .clk (clk), .rst (rst), .en (en), .in_valid (front_vld),
    .num (ri.dot2), .den (ri.nn), .out_valid (root_vld[1]), .root (along)
  );

  apem_root #(.NUM_W(apem_pkg::SQ2_W), .DEN_W(apem_pkg::NN_W)) u_across (
    .clk (clk), .rst (rst), .en (en), .in_valid (front_vld),
    .num (ri.c2), .den (ri.nn), .out_valid (root_vld[2]), .root (across)
  );

  apem_root #(.NUM_W(apem_pkg::ENUM_W), .DEN_W(apem_pkg::EDEN_W)) u_ellipse (
    .clk (clk), .rst (rst), .en (en), .in_valid (front_vld),
    .num (ri.ell_num), .den (ri.ell_den), .out_valid (root_vld[3]), .root (ellipse)
  );

  // normal_used flag follows the root stages
  logic used_dly [0:ERR_W-1];

  for (genvar i = 0; i < ERR_W; i++) begin : g_used
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        if (en) used_dly[0] <= ri.used;
      end
    end else begin : g_tail
      always_ff @(posedge clk) begin
        if (en) used_dly[i] <= used_dly[i-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // ratio to the radius; other results ride along
  // --------------------------------------------------------------------------
  apem_pkg::side_t               side_in, side_out;
  logic                          div_vld, div_exc;
  logic [ERR_W-1:0]              div_ell;
  logic [apem_pkg::RATIO_W-1:0]  div_ratio;

  always_comb begin
    side_in.euclid = euclid;
    side_in.along  = along;
    side_in.across = across;
    side_in.used   = used_dly[ERR_W-1];
  end

  apem_div #(.SIDE_W(SIDE_W)) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (root_vld[0]),
    .ell       (ellipse),
    .radius    (normal_radius),
    .side      (side_in),
    .out_valid (div_vld),
    .ell_out   (div_ell),
    .ratio     (div_ratio),
    .exceeded  (div_exc),
    .side_out  (side_out)
  );

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= div_vld;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.euclid_err  <= side_out.euclid;
      result.along_err   <= side_out.along;
      result.across_err  <= side_out.across;
      result.ellipse_err <= div_ell;
      result.err_ratio   <= div_ratio;
      result.normal_used <= side_out.used;
      result.exceeded    <= div_exc;
    end
  end

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_roots_lockstep: assert property (@(posedge clk) disable iff (rst)
    root_vld[0] == root_vld[1] && root_vld[0] == root_vld[2] &&
    root_vld[0] == root_vld[3])
    else $error("root units out of step");

  a_unused_normal: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.normal_used |->
      result.along_err == '0 && result.across_err == '0 &&
      result.ellipse_err == result.euclid_err)
    else $error("fallback to Euclidean error broken");

  a_zero_ratio: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.ellipse_err == '0 |-> result.err_ratio == '0)
    else $error("nonzero ratio for zero error");

  a_ellipse_bound: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.normal_used |-> result.ellipse_err >= result.along_err)
    else $error("ellipse error below normal error");

endmodule
